// File: src/lab_pkg.sv
// ----------------------------------------------------------------------------
// lab_pkg: shared widths, pipeline depths and helpers for the look-at basis
// Fixed-point widths used by the front end and by the normalise units.
// ----------------------------------------------------------------------------
package lab_pkg;

    localparam int IN_W      = 32;  // Q16.16 coordinates and results
    localparam int SC_W      = 31;  // unsigned axis scale
    localparam int DIF_W     = 33;  // exact coordinate difference
    localparam int MAG_W     = 63;  // widest vector magnitude (a*a + c*c)
    localparam int AL_W      = 31;  // aligned magnitude, below 2^31
    localparam int PROD_W    = 62;  // AL_W x AL_W and AL_W x SC_W products
    localparam int SUM_W     = 64;  // sum of three squares
    localparam int LEN_W     = 32;  // integer square root of SUM_W bits
    localparam int NUM_W     = 63;  // product plus half length
    localparam int Q_W       = 31;  // quotient, never above the scale
    localparam int SQ_STEPS  = 32;  // one root bit per stage
    localparam int DIV_STEPS = 31;  // one quotient bit per stage
    localparam int NVEC      = 3;

    localparam logic [5:0] ALIGN_POS = 6'd30;  // leading one lands on bit 30

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [AL_W-1:0]  t_al;

    // Position of the most significant set bit; zero for an all-zero word.
    function automatic logic [5:0] f_lead_one(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = i[5:0];
            end
        end
        return p;
    endfunction

endpackage

// File: src/lab_norm.sv
// ----------------------------------------------------------------------------
// lab_norm: scaled normalise of one sign-magnitude vector
// Align, sum of squares, bit-serial square root stages, long-division stages.
// ----------------------------------------------------------------------------
module lab_norm
    import lab_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [NVEC-1:0][MAG_W-1:0]     i_mag,
    input  logic [NVEC-1:0]                i_neg,
    input  logic [SC_W-1:0]                i_scale,
    output logic                           o_vld,
    output logic [NVEC-1:0][IN_W-1:0]      o_comp
);

    // align: find shift
    logic                         r1_vld;
    logic [NVEC-1:0][MAG_W-1:0]   r1_mag;
    logic [NVEC-1:0]              r1_neg;
    logic [SC_W-1:0]              r1_sc;
    logic [5:0]                   r1_p;
    // align: shift
    logic                         r2_vld;
    logic [NVEC-1:0][AL_W-1:0]    r2_al;
    logic [NVEC-1:0]              r2_neg;
    logic [SC_W-1:0]              r2_sc;
    // squares and scale products
    logic                         r3_vld;
    logic [NVEC-1:0][PROD_W-1:0]  r3_sq;
    logic [NVEC-1:0][PROD_W-1:0]  r3_pr;
    logic [NVEC-1:0]              r3_neg;
    // square-root pipeline, entry 0 holds the sum
    logic                         rs_vld [0:SQ_STEPS];
    logic [SUM_W-1:0]             rs_n   [0:SQ_STEPS];
    logic [SUM_W-1:0]             rs_res [0:SQ_STEPS];
    logic [NVEC-1:0][PROD_W-1:0]  rs_pr  [0:SQ_STEPS];
    logic [NVEC-1:0]              rs_neg [0:SQ_STEPS];
    // division pipeline, entry 0 holds the rounded numerators
    logic                         rd_vld  [0:DIV_STEPS];
    logic [NVEC-1:0][NUM_W-1:0]   rd_rem  [0:DIV_STEPS];
    logic [NVEC-1:0][Q_W-1:0]     rd_q    [0:DIV_STEPS];
    logic [LEN_W-1:0]             rd_len  [0:DIV_STEPS];
    logic                         rd_zero [0:DIV_STEPS];
    logic [NVEC-1:0]              rd_neg  [0:DIV_STEPS];
    // output
    logic                         r_vld_out;
    logic [NVEC-1:0][IN_W-1:0]    r_comp;

    logic [NVEC-1:0][AL_W-1:0]    n2_al;
    logic [MAG_W-1:0]             w_or;

    assign w_or = i_mag[0] | i_mag[1] | i_mag[2];

    always_comb begin
        t_mag tmp;
        for (int i = 0; i < NVEC; i++) begin
            tmp = (r1_p >= ALIGN_POS) ? (r1_mag[i] >> (r1_p - ALIGN_POS))
                                      : (r1_mag[i] << (ALIGN_POS - r1_p));
            n2_al[i] = tmp[AL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            rs_vld[0] <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            rs_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag <= i_mag;
            r1_neg <= i_neg;
            r1_sc  <= i_scale;
            r1_p   <= f_lead_one({1'b0, w_or});
            r2_al  <= n2_al;
            r2_neg <= r1_neg;
            r2_sc  <= r1_sc;
            for (int i = 0; i < NVEC; i++) begin
                r3_sq[i] <= PROD_W'(r2_al[i]) * PROD_W'(r2_al[i]);
                r3_pr[i] <= PROD_W'(r2_al[i]) * PROD_W'(r2_sc);
            end
            r3_neg <= r2_neg;
            rs_n[0]   <= SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);
            rs_res[0] <= '0;
            rs_pr[0]  <= r3_pr;
            rs_neg[0] <= r3_neg;
        end
    end

    // one root bit per stage, test bit walks down from 2^62
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (62 - 2 * k);
        logic [SUM_W-1:0] w_try;
        assign w_try = rs_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rs_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                rs_vld[k+1] <= rs_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rs_n[k] >= w_try) begin
                    rs_n[k+1]   <= rs_n[k] - w_try;
                    rs_res[k+1] <= (rs_res[k] >> 1) + BIT;
                end else begin
                    rs_n[k+1]   <= rs_n[k];
                    rs_res[k+1] <= rs_res[k] >> 1;
                end
                rs_pr[k+1]  <= rs_pr[k];
                rs_neg[k+1] <= rs_neg[k];
            end
        end
    end

    // add half the length for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld[0] <= 1'b0;
        end else if (i_en) begin
            rd_vld[0] <= rs_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NVEC; i++) begin
                rd_rem[0][i] <= NUM_W'(rs_pr[SQ_STEPS][i])
                              + NUM_W'(rs_res[SQ_STEPS][LEN_W-1:1]);
            end
            rd_q[0]    <= '0;
            rd_len[0]  <= rs_res[SQ_STEPS][LEN_W-1:0];
            rd_zero[0] <= (rs_res[SQ_STEPS][LEN_W-1:0] == '0);
            rd_neg[0]  <= rs_neg[SQ_STEPS];
        end
    end

    // restoring division, quotient bit 30 first; quotient never exceeds scale
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [NUM_W-1:0] w_div;
        assign w_div = NUM_W'(rd_len[j]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                rd_vld[j+1] <= rd_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < NVEC; i++) begin
                    if (rd_rem[j][i] >= w_div) begin
                        rd_rem[j+1][i] <= rd_rem[j][i] - w_div;
                        rd_q[j+1][i]   <= rd_q[j][i] | (Q_W'(1) << SH);
                    end else begin
                        rd_rem[j+1][i] <= rd_rem[j][i];
                        rd_q[j+1][i]   <= rd_q[j][i];
                    end
                end
                rd_len[j+1]  <= rd_len[j];
                rd_zero[j+1] <= rd_zero[j];
                rd_neg[j+1]  <= rd_neg[j];
            end
        end
    end

    // apply sign, zero-length vector gives zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld_out <= rd_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NVEC; i++) begin
                if (rd_zero[DIV_STEPS]) begin
                    r_comp[i] <= '0;
                end else if (rd_neg[DIV_STEPS][i]) begin
                    r_comp[i] <= IN_W'(0) - {1'b0, rd_q[DIV_STEPS][i]};
                end else begin
                    r_comp[i] <= {1'b0, rd_q[DIV_STEPS][i]};
                end
            end
        end
    end

    assign o_vld  = r_vld_out;
    assign o_comp = r_comp;

`ifndef SYNTHESIS
    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_vld) && $stable(o_comp))
        else $error("lab_norm: output moved while held");
    a_rst_vld: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vld && !r3_vld)
        else $error("lab_norm: valid survived reset");
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && rd_vld[DIV_STEPS] && rd_zero[DIV_STEPS] |=> o_comp == '0)
        else $error("lab_norm: zero-length vector gave nonzero result");
`endif

endmodule

// File: src/look_at_basis_unit.sv
// ----------------------------------------------------------------------------
// look_at_basis_unit: orientation basis pointing an object at a target
// Forms look, right and up axes, normalises each and scales by its length.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid / o_stall with position, target (signed Q16.16)
//   and three axis scales (unsigned Q15.16). A transfer happens on a rising
//   edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with the nine basis components. A
//   transfer happens on a rising edge with o_valid high and i_stall low.
//   Throughput: one item per cycle while the receiver takes results.
//   Stages: 6 front-end stages plus 4 + 32 + 1 + 31 + 1 normalise stages;
//   the root and the divide take one bit per stage.
//   Stall: the whole pipeline freezes while a result waits at the output
//   and the receiver stalls; o_stall rises in the same cycle, so nothing is
//   dropped or taken twice.
//   Reset: synchronous, active low; clears every valid bit, the pipeline
//   then holds no items.
// ----------------------------------------------------------------------------
module look_at_basis_unit
    import lab_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [31:0]  i_target_z,
    input  logic [30:0]         i_scale_right,
    input  logic [30:0]         i_scale_up,
    input  logic [30:0]         i_scale_look,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_right_x,
    output logic signed [31:0]  o_right_y,
    output logic signed [31:0]  o_right_z,
    output logic signed [31:0]  o_up_x,
    output logic signed [31:0]  o_up_y,
    output logic signed [31:0]  o_up_z,
    output logic signed [31:0]  o_look_x,
    output logic signed [31:0]  o_look_y,
    output logic signed [31:0]  o_look_z
);

    logic w_en;

    // difference
    logic                            r1_vld;
    logic signed [NVEC-1:0][DIF_W-1:0] r1_dif;
    logic [NVEC-1:0][SC_W-1:0]       r1_sc;
    // sign-magnitude
    logic                            r2_vld;
    logic [NVEC-1:0][DIF_W-1:0]      r2_mag;
    logic [NVEC-1:0]                 r2_neg;
    logic [NVEC-1:0][SC_W-1:0]       r2_sc;
    // alignment shift found
    logic                            r3_vld;
    logic [NVEC-1:0][DIF_W-1:0]      r3_mag;
    logic [NVEC-1:0]                 r3_neg;
    logic [NVEC-1:0][SC_W-1:0]       r3_sc;
    logic [5:0]                      r3_p;
    // aligned look a, b, c
    logic                            r4_vld;
    logic [NVEC-1:0][AL_W-1:0]       r4_al;
    logic [NVEC-1:0]                 r4_neg;
    logic [NVEC-1:0][SC_W-1:0]       r4_sc;
    // cross-product terms
    logic                            r5_vld;
    logic [PROD_W-1:0]               r5_ab, r5_aa, r5_cc, r5_bc;
    logic [NVEC-1:0][AL_W-1:0]       r5_al;
    logic [NVEC-1:0]                 r5_neg;
    logic [NVEC-1:0][SC_W-1:0]       r5_sc;
    // three vectors ready for normalising
    logic                            r6_vld;
    logic [NVEC-1:0][MAG_W-1:0]      r6_rmag, r6_umag, r6_lmag;
    logic [NVEC-1:0]                 r6_rneg, r6_uneg, r6_lneg;
    logic [NVEC-1:0][SC_W-1:0]       r6_sc;

    logic [NVEC-1:0][AL_W-1:0]       n4_al;
    logic [DIF_W-1:0]                w_or;
    logic                            w_vld_r, w_vld_u, w_vld_l;
    logic [NVEC-1:0][IN_W-1:0]       w_right, w_up, w_look;

    // freeze everything while a finished result is held back
    assign w_en    = !(w_vld_r && i_stall);
    assign o_stall = !w_en;

    assign w_or = r2_mag[0] | r2_mag[1] | r2_mag[2];

    // common shift so the largest magnitude lands in [2^30, 2^31)
    always_comb begin
        logic [DIF_W-1:0] tmp;
        for (int i = 0; i < NVEC; i++) begin
            tmp = (r3_p >= ALIGN_POS) ? (r3_mag[i] >> (r3_p - ALIGN_POS))
                                      : (r3_mag[i] << (ALIGN_POS - r3_p));
            n4_al[i] = tmp[AL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dif[0] <= $signed({i_target_x[31], i_target_x})
                       - $signed({i_pos_x[31], i_pos_x});
            r1_dif[1] <= $signed({i_target_y[31], i_target_y})
                       - $signed({i_pos_y[31], i_pos_y});
            r1_dif[2] <= $signed({i_target_z[31], i_target_z})
                       - $signed({i_pos_z[31], i_pos_z});
            r1_sc     <= {i_scale_look, i_scale_up, i_scale_right};

            for (int i = 0; i < NVEC; i++) begin
                r2_neg[i] <= r1_dif[i][DIF_W-1];
                r2_mag[i] <= r1_dif[i][DIF_W-1] ? DIF_W'(0) - r1_dif[i] : r1_dif[i];
            end
            r2_sc <= r1_sc;

            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_sc  <= r2_sc;
            r3_p   <= f_lead_one(64'(w_or));

            r4_al  <= n4_al;
            r4_neg <= r3_neg;
            r4_sc  <= r3_sc;

            r5_ab  <= PROD_W'(r4_al[0]) * PROD_W'(r4_al[1]);
            r5_aa  <= PROD_W'(r4_al[0]) * PROD_W'(r4_al[0]);
            r5_cc  <= PROD_W'(r4_al[2]) * PROD_W'(r4_al[2]);
            r5_bc  <= PROD_W'(r4_al[1]) * PROD_W'(r4_al[2]);
            r5_al  <= r4_al;
            r5_neg <= r4_neg;
            r5_sc  <= r4_sc;

            // right = (c, 0, -a)
            r6_rmag[0] <= MAG_W'(r5_al[2]);
            r6_rmag[1] <= '0;
            r6_rmag[2] <= MAG_W'(r5_al[0]);
            r6_rneg[0] <= r5_neg[2];
            r6_rneg[1] <= 1'b0;
            r6_rneg[2] <= (r5_al[0] != '0) && !r5_neg[0];
            // up = (-ab, aa + cc, -bc)
            r6_umag[0] <= MAG_W'(r5_ab);
            r6_umag[1] <= MAG_W'(r5_aa) + MAG_W'(r5_cc);
            r6_umag[2] <= MAG_W'(r5_bc);
            r6_uneg[0] <= (r5_ab != '0) && (r5_neg[0] == r5_neg[1]);
            r6_uneg[1] <= 1'b0;
            r6_uneg[2] <= (r5_bc != '0) && (r5_neg[1] == r5_neg[2]);
            // look as aligned
            for (int i = 0; i < NVEC; i++) begin
                r6_lmag[i] <= MAG_W'(r5_al[i]);
            end
            r6_lneg <= r5_neg;
            r6_sc   <= r5_sc;
        end
    end

    lab_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_mag   (r6_rmag),
        .i_neg   (r6_rneg),
        .i_scale (r6_sc[0]),
        .o_vld   (w_vld_r),
        .o_comp  (w_right)
    );

    lab_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_mag   (r6_umag),
        .i_neg   (r6_uneg),
        .i_scale (r6_sc[1]),
        .o_vld   (w_vld_u),
        .o_comp  (w_up)
    );

    lab_norm u_norm_look (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_mag   (r6_lmag),
        .i_neg   (r6_lneg),
        .i_scale (r6_sc[2]),
        .o_vld   (w_vld_l),
        .o_comp  (w_look)
    );

    assign o_valid   = w_vld_r;
    assign o_right_x = w_right[0];
    assign o_right_y = w_right[1];
    assign o_right_z = w_right[2];
    assign o_up_x    = w_up[0];
    assign o_up_y    = w_up[1];
    assign o_up_z    = w_up[2];
    assign o_look_x  = w_look[0];
    assign o_look_y  = w_look[1];
    assign o_look_z  = w_look[2];

`ifndef SYNTHESIS
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_r == w_vld_u) && (w_vld_r == w_vld_l))
        else $error("look_at_basis_unit: normalise lanes out of step");
    a_right_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_right_y == '0)
        else $error("look_at_basis_unit: right y not zero");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("look_at_basis_unit: stall without a held result");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r6_vld)
        else $error("look_at_basis_unit: valid survived reset");
`endif

endmodule
